>>> design/jpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_pkg
// Shared types and constants of the camera package deframer: field widths,
// header bytes, status codes and the command and flag groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package jpd_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int PKG_SIZE_W = 10;
    localparam int LEN_W     = 24;
    localparam int ID_W      = 16;
    localparam int DIVISOR_W = 9;
    localparam int HIDX_W    = 3;
    localparam int STATUS_W  = 3;

    // Package framing.
    localparam logic [PKG_SIZE_W-1:0] PKG_SIZE_MIN   = 10'd64;
    localparam logic [PKG_SIZE_W-1:0] PKG_OVERHEAD   = 10'd6;
    localparam logic [PKG_SIZE_W-1:0] PKG_SIZE_RESET = 10'd512;

    // DATA reply layout.
    localparam logic [BYTE_W-1:0] HDR_SYNC0     = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_SYNC1     = 8'h0A;
    localparam logic [HIDX_W-1:0] HDR_IDX_SYNC0 = 3'd0;
    localparam logic [HIDX_W-1:0] HDR_IDX_SYNC1 = 3'd1;
    localparam logic [HIDX_W-1:0] HDR_IDX_LEN0  = 3'd3;
    localparam logic [HIDX_W-1:0] HDR_IDX_LEN1  = 3'd4;
    localparam logic [HIDX_W-1:0] HDR_IDX_LEN2  = 3'd5;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_HEADER  = 3'd1,
        ST_ID_MISMATCH = 3'd2,
        ST_SIZE_LARGE  = 3'd3,
        ST_CHECKSUM    = 3'd4
    } status_t;

    // Receiver phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_ID     = 7'b0000100,
        PH_SIZE   = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_VERIFY = 7'b0100000,
        PH_STOP   = 7'b1000000
    } phase_t;

    // Commands from the controller to the datapath, valid for one byte.
    typedef struct packed {
        logic    fire;
        logic    hdr_step;
        logic    hdr_finish;
        logic    field_byte;
        logic    load_size;
        logic    data_byte;
        logic    verify_byte;
        logic    pkg_ack;
        logic    pkg_advance;
        logic    done;
        status_t err;
    } jpd_cmd_t;

    // Flags from the datapath to the controller.
    typedef struct packed {
        logic hdr_bad;
        logic hdr_last;
        logic second_byte;
        logic id_match;
        logic size_large;
        logic size_zero;
        logic data_last;
        logic sum_match;
        logic last_pkg;
        logic out_valid;
        logic div_busy;
    } jpd_flags_t;

endpackage
`default_nettype wire

>>> design/jpd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_divider
// Restoring divider for the package count: image length over the payload
// capacity of one package, one quotient bit per cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module jpd_divider
    import jpd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start_i,
    input  wire logic [LEN_W-1:0]     dividend_i,
    input  wire logic [DIVISOR_W-1:0] divisor_i,
    output logic                      busy_o,
    output logic                      done_o,
    output logic [ID_W-1:0]           quotient_o
);

    localparam int STEP_W = $clog2(LEN_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [LEN_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[LEN_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start_i) begin
            busy_next = 1'b1;
            step_next = STEP_W'(LEN_W - 1);
            quo_next  = dividend_i;
            rem_next  = '0;
            div_next  = divisor_i;
        end else if (busy_reg) begin
            quo_next = {quo_reg[LEN_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // A count beyond 16 bits saturates.
    assign busy_o     = busy_reg;
    assign done_o     = done_reg;
    assign quotient_o = (|quo_reg[LEN_W-1:ID_W]) ? '1 : quo_reg[ID_W-1:0];

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> !busy_reg)
        else $error("divider started while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |=> busy_reg)
        else $error("divider did not go busy after start");
`endif

endmodule
`default_nettype wire

>>> design/jpd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_ctrl
// Phase sequencer of the deframer. Decides the input handshake and, for each
// accepted byte, the commands that the datapath carries out.
// ----------------------------------------------------------------------------
module jpd_ctrl
    import jpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       start_req,
    input  wire logic       m_tready,
    input  wire jpd_flags_t flags,
    output logic            s_tready,
    output jpd_cmd_t        cmd
);

    phase_t phase_reg, phase_next;
    phase_t phase_eff;
    logic   fire;

    // A byte is taken when the result slot is free and no division runs.
    assign s_tready = (!flags.out_valid || m_tready) && !flags.div_busy;
    assign fire     = s_tvalid && s_tready;

    // A start request restarts the header at once, whatever the phase.
    assign phase_eff = start_req ? PH_HEADER : phase_reg;

    always_comb begin
        cmd        = '0;
        cmd.err    = ST_OK;
        cmd.fire   = fire;
        phase_next = phase_reg;
        if (fire) begin
            phase_next = phase_eff;
            case (phase_eff)
                PH_HEADER: begin
                    if (flags.hdr_bad) begin
                        cmd.err    = ST_BAD_HEADER;
                        phase_next = PH_STOP;
                    end else if (flags.hdr_last) begin
                        cmd.hdr_finish = 1'b1;
                        phase_next     = PH_ID;
                    end else begin
                        cmd.hdr_step = 1'b1;
                    end
                end
                PH_ID: begin
                    cmd.field_byte = 1'b1;
                    if (flags.second_byte) begin
                        if (flags.id_match) begin
                            phase_next = PH_SIZE;
                        end else begin
                            cmd.err    = ST_ID_MISMATCH;
                            phase_next = PH_STOP;
                        end
                    end
                end
                PH_SIZE: begin
                    cmd.field_byte = 1'b1;
                    if (flags.second_byte) begin
                        if (flags.size_large) begin
                            cmd.err    = ST_SIZE_LARGE;
                            phase_next = PH_STOP;
                        end else begin
                            cmd.load_size = 1'b1;
                            phase_next    = flags.size_zero ? PH_VERIFY : PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    cmd.data_byte = 1'b1;
                    if (flags.data_last) begin
                        phase_next = PH_VERIFY;
                    end
                end
                PH_VERIFY: begin
                    cmd.verify_byte = 1'b1;
                    if (flags.second_byte) begin
                        if (!flags.sum_match) begin
                            cmd.err    = ST_CHECKSUM;
                            phase_next = PH_STOP;
                        end else if (flags.last_pkg) begin
                            cmd.pkg_ack = 1'b1;
                            cmd.done    = 1'b1;
                            phase_next  = PH_STOP;
                        end else begin
                            cmd.pkg_ack     = 1'b1;
                            cmd.pkg_advance = 1'b1;
                            phase_next      = PH_ID;
                        end
                    end
                end
                default: begin
                    // Idle or stopped: the byte is dropped with an empty result.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_no_fire_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fire |-> !flags.div_busy)
        else $error("byte taken while the package count is being divided");
`endif

endmodule
`default_nettype wire

>>> design/jpd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_datapath
// Header, ID, size and checksum registers of the deframer, the package size
// register, the package-count divider and the result register.
// ----------------------------------------------------------------------------
module jpd_datapath
    import jpd_pkg::*;
#(
    parameter int MAX_PACKAGE_BYTES = 512
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [BYTE_W-1:0]     rx_byte,
    input  wire logic                  start_req,
    input  wire logic                  cfg_valid,
    input  wire logic [PKG_SIZE_W-1:0] cfg_data,
    input  wire jpd_cmd_t              cmd,
    input  wire logic                  m_tready,
    output jpd_flags_t                 flags,
    output logic                       m_tvalid,
    output logic [31:0]                m_tdata,
    output logic [1:0]                 m_tuser
);

    localparam logic [PKG_SIZE_W-1:0] SIZE_MAX = PKG_SIZE_W'(MAX_PACKAGE_BYTES);

    // Package size register and its saturated value.
    logic [PKG_SIZE_W-1:0] pkg_size_reg;
    logic [PKG_SIZE_W-1:0] pkg_size_eff;
    logic [PKG_SIZE_W-1:0] capacity;

    // Framing state.
    logic [HIDX_W-1:0]     hidx_reg, hidx_next, hidx_eff;
    logic [LEN_W-1:0]      len_reg, len_next, len_eff, len_merged;
    logic [ID_W-1:0]       pkg_total_reg;
    logic [ID_W-1:0]       pkg_index_reg, pkg_index_next;
    logic [PKG_SIZE_W-1:0] payload_reg, payload_next;
    logic [PKG_SIZE_W-1:0] count_reg, count_next;
    logic [PKG_SIZE_W:0]   count_inc;
    logic [BYTE_W-1:0]     sum_reg, sum_next;
    logic [BYTE_W-1:0]     low_reg, low_next;
    logic [ID_W-1:0]       word;

    // Result register.
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     data_byte_reg;
    logic                  data_valid_reg;
    logic                  ack_request_reg;
    logic [ID_W-1:0]       ack_package_reg;
    status_t               status_reg;
    logic                  picture_done_reg;

    // Divider link.
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [ID_W-1:0]       div_quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkg_size_reg <= PKG_SIZE_RESET;
        end else if (cfg_valid) begin
            pkg_size_reg <= cfg_data;
        end
    end

    always_comb begin
        if (pkg_size_reg < PKG_SIZE_MIN) begin
            pkg_size_eff = PKG_SIZE_MIN;
        end else if (pkg_size_reg > SIZE_MAX) begin
            pkg_size_eff = SIZE_MAX;
        end else begin
            pkg_size_eff = pkg_size_reg;
        end
    end

    assign capacity = pkg_size_eff - PKG_OVERHEAD;

    // A start request is seen as header byte zero of an empty length.
    assign hidx_eff = start_req ? '0 : hidx_reg;
    assign len_eff  = start_req ? '0 : len_reg;

    always_comb begin
        len_merged = len_eff;
        case (hidx_eff)
            HDR_IDX_LEN0: len_merged[7:0]   = len_eff[7:0] | rx_byte;
            HDR_IDX_LEN1: len_merged[15:8]  = len_eff[15:8] | rx_byte;
            HDR_IDX_LEN2: len_merged[23:16] = len_eff[23:16] | rx_byte;
            default:      len_merged        = len_eff;
        endcase
    end

    assign word      = {rx_byte, low_reg};
    assign count_inc = {1'b0, count_reg} + 1'b1;

    // Status towards the controller.
    always_comb begin
        flags.hdr_bad     = ((hidx_eff == HDR_IDX_SYNC0) && (rx_byte != HDR_SYNC0)) ||
                            ((hidx_eff == HDR_IDX_SYNC1) && (rx_byte != HDR_SYNC1));
        flags.hdr_last    = hidx_eff >= HDR_IDX_LEN2;
        flags.second_byte = count_reg != '0;
        flags.id_match    = word == pkg_index_reg;
        flags.size_large  = word > {{(ID_W-PKG_SIZE_W){1'b0}}, capacity};
        flags.size_zero   = word == '0;
        flags.data_last   = count_inc >= {1'b0, payload_reg};
        flags.sum_match   = word == {{(ID_W-BYTE_W){1'b0}}, sum_reg};
        flags.last_pkg    = pkg_index_reg == pkg_total_reg;
        flags.out_valid   = out_valid_reg;
        flags.div_busy    = div_busy;
    end

    // Next values of the framing registers.
    always_comb begin
        hidx_next      = hidx_reg;
        len_next       = len_reg;
        pkg_index_next = pkg_index_reg;
        payload_next   = payload_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        low_next       = low_reg;
        if (cmd.fire && start_req) begin
            hidx_next = '0;
            len_next  = '0;
        end
        if (cmd.hdr_step) begin
            hidx_next = hidx_eff + 1'b1;
            len_next  = len_merged;
        end
        if (cmd.hdr_finish) begin
            len_next       = len_merged;
            pkg_index_next = '0;
            sum_next       = '0;
            count_next     = '0;
        end
        if (cmd.field_byte || cmd.data_byte) begin
            sum_next = sum_reg + rx_byte;
        end
        if (cmd.field_byte || cmd.verify_byte) begin
            if (flags.second_byte) begin
                count_next = '0;
            end else begin
                low_next   = rx_byte;
                count_next = PKG_SIZE_W'(1);
            end
        end
        if (cmd.load_size) begin
            payload_next = word[PKG_SIZE_W-1:0];
        end
        if (cmd.data_byte) begin
            count_next = flags.data_last ? '0 : count_inc[PKG_SIZE_W-1:0];
        end
        if (cmd.pkg_ack) begin
            sum_next = '0;
        end
        if (cmd.pkg_advance) begin
            pkg_index_next = pkg_index_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hidx_reg      <= '0;
            len_reg       <= '0;
            pkg_total_reg <= '0;
            pkg_index_reg <= '0;
            payload_reg   <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            low_reg       <= '0;
        end else begin
            hidx_reg      <= hidx_next;
            len_reg       <= len_next;
            pkg_index_reg <= pkg_index_next;
            payload_reg   <= payload_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            low_reg       <= low_next;
            if (div_done) begin
                pkg_total_reg <= div_quotient;
            end
        end
    end

    // The package count is worked out while input is held off.
    assign div_start = cmd.hdr_finish;

    jpd_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (len_merged),
        .divisor_i  (capacity[DIVISOR_W-1:0]),
        .busy_o     (div_busy),
        .done_o     (div_done),
        .quotient_o (div_quotient)
    );

    // Result register: loaded for every accepted byte, held until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.fire) begin
            data_byte_reg    <= cmd.data_byte ? rx_byte : '0;
            data_valid_reg   <= cmd.data_byte;
            ack_request_reg  <= cmd.hdr_finish || cmd.pkg_ack;
            ack_package_reg  <= cmd.pkg_ack ? (pkg_index_reg + 1'b1) : '0;
            status_reg       <= cmd.err;
            picture_done_reg <= cmd.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, picture_done_reg, status_reg, ack_package_reg, data_byte_reg};
    assign m_tuser  = {ack_request_reg, data_valid_reg};

`ifndef SYNTHESIS
    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (status_reg != ST_OK) |-> !data_valid_reg && !ack_request_reg)
        else $error("error result carries data or an acknowledgement request");
    a_done_acks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && picture_done_reg |-> ack_request_reg)
        else $error("picture done without an acknowledgement request");
`endif

endmodule
`default_nettype wire

>>> design/jpeg_package_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_package_deframer
// Receiver for the picture data of a serial camera: checks the DATA reply,
// counts the packages, checks each package ID, size and checksum, passes the
// payload through and requests the acknowledgements.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction carries
//  s_        in         one received byte and its start mark
//  m_        out        one result per received byte
//  cfg_      in         package size register write
//
//  The registered result of an accepted byte is valid in the cycle after it.
//  The last DATA-reply byte starts the package-count division, a restoring
//  divider with one quotient bit per cycle, so s_tready stays low until it ends.
//  While a result waits and m_tready is low, s_tready is low.
//  Reset clears the phase, counters and result valid, and sets the package
//  size register to 512.
// ----------------------------------------------------------------------------
module jpeg_package_deframer
    import jpd_pkg::*;
#(
    parameter int MAX_PACKAGE_BYTES = 512
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] data_byte, [23:8] ack_package,
                                        // [26:24] status, [27] picture_done
    output logic [1:0]       m_tuser,   // [0] data_valid, [1] ack_request
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data   // [9:0] package_size
);

    jpd_cmd_t   cmd;
    jpd_flags_t flags;

    // The register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    jpd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .start_req (s_tuser[0]),
        .m_tready  (m_tready),
        .flags     (flags),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    jpd_datapath #(
        .MAX_PACKAGE_BYTES (MAX_PACKAGE_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_byte   (s_tdata),
        .start_req (s_tuser[0]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .flags     (flags),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the camera package deframer. Camera byte streams
// (DATA replies, packages, faults, restarts and line noise) are driven into
// the slave side. A cycle-free model of the receiver predicts one result per
// accepted byte, and every result on the master side is compared with it.
// The package size register is changed between phases, and both sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jpd_pkg::*;

    localparam int MAX_PKG       = 512;
    localparam int SETTLE_CYCLES = 32;   // covers the package-count divider
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 250;
    localparam int N_PHASES      = 8;
    localparam int N_DIRECTED    = 28;
    localparam int SAT_PACKAGES  = 20;

    // One deframer result, its fields in the order that the checker compares them.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        ack_request;
        logic [15:0] ack_package;
        status_t     status;
        logic        picture_done;
    } frame_res_t;

    // Directed stimulus row; the result fields are used only when pinned.
    typedef struct {
        logic [7:0]  rx;
        logic        sop;
        bit          pinned;
        logic        ack;
        logic [15:0] pkg;
        status_t     st;
        logic        done;
    } dir_row_t;

    // Faults that the stream generator can inject into a package.
    typedef enum int {
        PK_CLEAN,
        PK_BAD_ID,
        PK_OVERSIZE,
        PK_BAD_SUM,
        PK_CUT
    } pkt_fault_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]  s_tuser   = '0;   // [0] start_req
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [7:0] data_byte, [23:8] ack_package,
                                   // [26:24] status, [27] picture_done
    logic [1:0]  m_tuser;          // [0] data_valid, [1] ack_request
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data  = '0;   // [9:0] package_size

    // Model state of the receiver, starting from its reset values.
    phase_t      rx_phase     = PH_IDLE;
    logic [2:0]  hdr_idx      = '0;
    logic [23:0] img_len      = '0;
    logic [15:0] last_pkg     = '0;
    logic [15:0] pkg_idx      = '0;
    logic [15:0] pay_size     = '0;
    logic [15:0] byte_cnt     = '0;
    logic [7:0]  csum         = '0;
    logic [7:0]  lo_byte      = '0;
    logic [9:0]  pkg_size_reg = PKG_SIZE_RESET;

    frame_res_t  frame_q[$];
    int unsigned n_items     = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int unsigned s_gap_pct   = 0;
    int unsigned r_stall_pct = 0;

    // Directed stream: idle bytes, header faults, a complete one-package
    // picture, the longest image length and an oversized package.
    dir_row_t dir_rows [N_DIRECTED] = '{
        '{8'h55, 1'b0, 1'b1, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hAA, 1'b1, 1'b1, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h0B, 1'b0, 1'b1, 1'b0, 16'h0000, ST_BAD_HEADER,  1'b0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 16'h0000, ST_BAD_HEADER,  1'b0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h03, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0001, ST_OK,          1'b1},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'hFB, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK,          1'b0},
        '{8'h01, 1'b0, 1'b1, 1'b0, 16'h0000, ST_SIZE_LARGE,  1'b0}
    };

    jpeg_package_deframer #(
        .MAX_PACKAGE_BYTES(MAX_PKG)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Clock with a 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Package size in use, with the register clamped to the legal range.
    function automatic int unsigned eff_size();
        int unsigned p;
        p = pkg_size_reg;
        if (p < PKG_SIZE_MIN) p = PKG_SIZE_MIN;
        if (p > MAX_PKG) p = MAX_PKG;
        return p;
    endfunction

    // Advances the receiver model by one byte and returns its result.
    function automatic frame_res_t deframe_byte(input logic [7:0] b, input logic sop);
        frame_res_t  r;
        int unsigned q;
        r = '0;
        r.status = ST_OK;
        if (sop) begin
            rx_phase = PH_HEADER;
            hdr_idx  = '0;
            img_len  = '0;
        end
        case (rx_phase)
            PH_HEADER: begin
                if ((hdr_idx == HDR_IDX_SYNC0 && b != HDR_SYNC0) ||
                    (hdr_idx == HDR_IDX_SYNC1 && b != HDR_SYNC1)) begin
                    r.status = ST_BAD_HEADER;
                    rx_phase = PH_STOP;
                end else begin
                    if (hdr_idx >= HDR_IDX_LEN0)
                        img_len = img_len | (24'(b) << (8 * (hdr_idx - HDR_IDX_LEN0)));
                    if (hdr_idx == HDR_IDX_LEN2) begin
                        q = img_len / (eff_size() - PKG_OVERHEAD);
                        last_pkg = (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
                        pkg_idx  = '0;
                        csum     = '0;
                        byte_cnt = '0;
                        r.ack_request = 1'b1;
                        rx_phase = PH_ID;
                    end else begin
                        hdr_idx = hdr_idx + 3'd1;
                    end
                end
            end
            PH_ID: begin
                csum = csum + b;
                if (byte_cnt == 0) begin
                    lo_byte  = b;
                    byte_cnt = 16'd1;
                end else begin
                    byte_cnt = '0;
                    if ({b, lo_byte} != pkg_idx) begin
                        r.status = ST_ID_MISMATCH;
                        rx_phase = PH_STOP;
                    end else begin
                        rx_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                csum = csum + b;
                if (byte_cnt == 0) begin
                    lo_byte  = b;
                    byte_cnt = 16'd1;
                end else begin
                    byte_cnt = '0;
                    pay_size = {b, lo_byte};
                    if (pay_size > eff_size() - PKG_OVERHEAD) begin
                        r.status = ST_SIZE_LARGE;
                        rx_phase = PH_STOP;
                    end else begin
                        rx_phase = (pay_size == 0) ? PH_VERIFY : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                csum = csum + b;
                r.data_byte  = b;
                r.data_valid = 1'b1;
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= pay_size) begin
                    byte_cnt = '0;
                    rx_phase = PH_VERIFY;
                end
            end
            PH_VERIFY: begin
                if (byte_cnt == 0) begin
                    lo_byte  = b;
                    byte_cnt = 16'd1;
                end else begin
                    byte_cnt = '0;
                    if ({b, lo_byte} != {8'h00, csum}) begin
                        r.status = ST_CHECKSUM;
                        rx_phase = PH_STOP;
                    end else begin
                        r.ack_request = 1'b1;
                        r.ack_package = pkg_idx + 16'd1;
                        csum = '0;
                        if (pkg_idx == last_pkg) begin
                            r.picture_done = 1'b1;
                            rx_phase = PH_STOP;
                        end else begin
                            pkg_idx  = pkg_idx + 16'd1;
                            rx_phase = PH_ID;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("%0t: result %0d: %s is 0x%0h, predicted 0x%0h",
                 $time, n_results, what, got, want);
    endtask

    // Sends one byte; called and returning at a falling edge. The valid stays
    // high on return so that back-to-back bytes need no gap.
    task automatic send_rx(input logic [7:0] b, input logic sop,
                           input bit pinned = 1'b0, input frame_res_t pinned_res = '0);
        frame_res_t r;
        while ($urandom_range(0, 99) < s_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sop;
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = deframe_byte(b, sop);
        frame_q.push_back(pinned ? pinned_res : r);
        n_items++;
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted result has been seen.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (frame_q.size() != 0) @(negedge aclk);
    endtask

    // Writes the package size register with the block idle.
    task automatic write_pkg_size(input logic [9:0] v);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        pkg_size_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One picture: a DATA reply and its packages, with occasional faults,
    // truncations and stray bytes. A picture that stops early leaves the next
    // start to restart the receiver mid-picture.
    task automatic send_picture();
        int unsigned room, last, len, count, sel, nsend, sz;
        bit          huge;
        pkt_fault_t  fault;
        logic [15:0] id, code;
        logic [7:0]  sum;
        logic [7:0]  hdr[$];
        logic [7:0]  pkt[$];
        room = eff_size() - PKG_OVERHEAD;

        // Line noise between pictures.
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 4)) send_rx(8'($urandom), 1'b0);

        // Image length, mostly for one to four packages.
        sel  = $urandom_range(0, 9);
        huge = (sel == 9);
        last = (sel < 5) ? 0 : (sel < 8) ? 1 : $urandom_range(2, 3);
        len  = huge ? ($urandom & 24'hFFFFFF) : last * room + $urandom_range(0, room - 1);
        count = huge ? $urandom_range(1, 3) : last + 1;
        if (count > len / room + 1) count = len / room + 1;

        // DATA reply, sometimes with a bad sync byte or cut short.
        hdr = '{HDR_SYNC0, HDR_SYNC1, 8'($urandom), len[7:0], len[15:8], len[23:16]};
        nsend = 6;
        sel = $urandom_range(0, 49);
        if (sel == 0) begin
            hdr[0] = HDR_SYNC0 ^ (8'd1 << $urandom_range(0, 7));
            nsend = 1;
        end else if (sel == 1) begin
            hdr[1] = HDR_SYNC1 ^ (8'd1 << $urandom_range(0, 7));
            nsend = 2;
        end else if (sel == 2) begin
            nsend = $urandom_range(1, 5);
        end
        for (int unsigned i = 0; i < nsend; i++) send_rx(hdr[i], i == 0);
        if (nsend < 6) return;

        for (int unsigned p = 0; p < count; p++) begin
            sel = $urandom_range(0, 99);
            fault = (sel < 2) ? PK_BAD_ID : (sel < 4) ? PK_OVERSIZE :
                    (sel < 7) ? PK_BAD_SUM : (sel < 9) ? PK_CUT : PK_CLEAN;

            id = p[15:0];
            if (fault == PK_BAD_ID) id = id ^ (16'd1 << $urandom_range(0, 15));
            sel = $urandom_range(0, 39);
            if (fault == PK_OVERSIZE)
                sz = $urandom_range(0, 1) ? room + 1 : $urandom_range(room + 1, 65535);
            else if (sel == 0)
                sz = 0;
            else if (sel == 1)
                sz = room;
            else if (sel < 4)
                sz = $urandom_range(0, room);
            else
                sz = $urandom_range(1, 12);

            pkt = '{id[7:0], id[15:8], sz[7:0], sz[15:8]};
            if (fault != PK_OVERSIZE) begin
                repeat (sz) pkt.push_back(8'($urandom));
                sum = '0;
                foreach (pkt[i]) sum = sum + pkt[i];
                code = {8'h00, sum};
                if (fault == PK_BAD_SUM) code = code ^ (16'd1 << $urandom_range(0, 15));
                pkt.push_back(code[7:0]);
                pkt.push_back(code[15:8]);
            end

            case (fault)
                PK_BAD_ID:   nsend = 2;
                PK_OVERSIZE: nsend = 4;
                PK_CUT:      nsend = $urandom_range(0, pkt.size() - 1);
                default:     nsend = pkt.size();
            endcase
            for (int unsigned i = 0; i < nsend; i++) send_rx(pkt[i], 1'b0);
            if (fault != PK_CLEAN) return;
        end
    endtask

    // Receiver side: ready drops at random in the stalling phases.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= r_stall_pct);
    end

    // Every result transaction is compared with the oldest prediction.
    always @(posedge aclk) begin : check_results
        frame_res_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            n_results++;
            if (frame_q.size() == 0) begin
                report_mismatch("unpredicted result", m_tdata, '0);
            end else begin
                want = frame_q.pop_front();
                if (m_tdata[7:0] !== want.data_byte)
                    report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
                if (m_tuser[0] !== want.data_valid)
                    report_mismatch("data_valid", m_tuser[0], want.data_valid);
                if (m_tuser[1] !== want.ack_request)
                    report_mismatch("ack_request", m_tuser[1], want.ack_request);
                if (m_tdata[23:8] !== want.ack_package)
                    report_mismatch("ack_package", m_tdata[23:8], want.ack_package);
                if (m_tdata[26:24] !== want.status)
                    report_mismatch("status", m_tdata[26:24], want.status);
                if (m_tdata[27] !== want.picture_done)
                    report_mismatch("picture_done", m_tdata[27], want.picture_done);
                if (m_tdata[31:28] !== 4'h0)
                    report_mismatch("tdata padding", m_tdata[31:28], '0);
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("jpeg_package_deframer regression: fail");
        $finish;
    end

    // Main sequence.
    initial begin
        logic [9:0]  sizes [N_PHASES];
        int unsigned phase_end;
        logic [7:0]  lo, hi;
        sizes = '{10'd64, 10'd0, 10'd1023, 10'd100, 10'd513, 10'd63, 10'd512, 10'd0};
        sizes[N_PHASES - 1] = 10'($urandom_range(0, 1023));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows at the reset package size, without idling.
        foreach (dir_rows[i])
            send_rx(dir_rows[i].rx, dir_rows[i].sop, dir_rows[i].pinned,
                    '{8'h00, 1'b0, dir_rows[i].ack, dir_rows[i].pkg,
                      dir_rows[i].st, dir_rows[i].done});

        // Random pictures, cycling through package sizes and idling patterns.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_pkg_size(sizes[ph]);
            case (ph % 4)
                0: begin s_gap_pct = 0;  r_stall_pct = 0;  end
                1: begin s_gap_pct = 85; r_stall_pct = 0;  end
                2: begin s_gap_pct = 0;  r_stall_pct = 85; end
                default: begin s_gap_pct = 15; r_stall_pct = 15; end
            endcase
            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end) begin
                if ($urandom_range(0, 7) == 0) hold_until_drained();
                send_picture();
            end
        end

        // A clamped package size and the longest length give a saturated
        // package count; a run of empty packages follows.
        s_gap_pct   = 0;
        r_stall_pct = 0;
        write_pkg_size(10'd7);
        send_rx(HDR_SYNC0, 1'b1);
        send_rx(HDR_SYNC1, 1'b0);
        send_rx(8'h00, 1'b0);
        repeat (3) send_rx(8'hFF, 1'b0);
        for (int p = 0; p < SAT_PACKAGES; p++) begin
            lo = p[7:0];
            hi = p[15:8];
            send_rx(lo, 1'b0);
            send_rx(hi, 1'b0);
            send_rx(8'h00, 1'b0);
            send_rx(8'h00, 1'b0);
            send_rx(lo + hi, 1'b0);
            send_rx(8'h00, 1'b0);
        end

        // Drain, then watch for stray results.
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (frame_q.size() != 0)
            report_mismatch("results still outstanding", frame_q.size(), '0);

        if (n_errors == 0)
            $display("jpeg_package_deframer regression: pass");
        else
            $display("jpeg_package_deframer regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/jpd_pkg.sv
design/jpd_divider.sv
design/jpd_ctrl.sv
design/jpd_datapath.sv
design/jpeg_package_deframer.sv
dv/tb_top.sv
